// ----- hw/rtl/weighted_round_robin_policy_pick_core_defines.svh -----
// Assertion macros for the weighted round-robin pick core.
// Included by the top level only; bodies are empty under SYNTHESIS.
`ifndef WEIGHTED_ROUND_ROBIN_POLICY_PICK_CORE_DEFINES_SVH
`define WEIGHTED_ROUND_ROBIN_POLICY_PICK_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define WRRP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define WRRP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define WRRP_ASSERT(lbl, prop, msg)
`define WRRP_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ----- hw/rtl/wrrp_pkg.sv -----
// Shared types and constants for the weighted round-robin pick core.
// No dependencies.
package wrrp_pkg;

    localparam int NUM_QUEUES  = 6;   // 2..8
    localparam int BUSY_W      = 6;   // busy bits carried per word
    localparam int WEIGHT_REGS = 6;   // writable weight registers
    localparam int QUEUE_W     = 3;
    localparam int WEIGHT_W    = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int IN_DATA_W   = 8;
    localparam int OUT_DATA_W  = 8;

    typedef logic [QUEUE_W-1:0]  queue_t;
    typedef logic [WEIGHT_W-1:0] weight_t;

    localparam weight_t WEIGHT_RESET = weight_t'(1);

    function automatic queue_t next_queue(input queue_t q);
        queue_t n;
        begin
            if (q == queue_t'(NUM_QUEUES - 1))
            begin
                n = '0;
            end
            else
            begin
                n = q + queue_t'(1);
            end
            return n;
        end
    endfunction

endpackage

// ----- hw/rtl/weighted_round_robin_policy_pick_core.sv -----
// Weighted round-robin pick core: input register, combinational rotating search,
// result register. Depends on wrrp_pkg and the defines header.
// Usage:
//   s_axis carries one request word per handshake: busy mask of the queues
//   and the track-full flag. m_axis returns one decision word per request:
//   grant valid flag and granted queue index (0 when nothing granted).
//   Weights are written through cfg_wen/cfg_idx/cfg_wdata, index i selects
//   the weight of queue i; indexes beyond the last weight are ignored.
//   Weights should only change while no request is in flight.
// Timing:
//   The result word follows the input handshake through the input register
//   and then the result register. One word per cycle is sustained while
//   m_axis_tready stays high; the only loop is the turn count and current
//   queue, closed through the combinational rotating priority search.
// Reset:
//   rst_n clears both stages, sets every weight to 1, the current queue to 0
//   and the turn count to 1.
// Backpressure:
//   When m_axis_tready is low the result word holds, the input register
//   holds behind it and s_axis_tready drops once both are full.
`include "weighted_round_robin_policy_pick_core_defines.svh"

module weighted_round_robin_policy_pick_core
(
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration
    input  logic                              cfg_wen,
    input  logic [wrrp_pkg::CFG_IDX_W-1:0]    cfg_idx,
    input  logic [wrrp_pkg::WEIGHT_W-1:0]     cfg_wdata,
    // request words
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [wrrp_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // [5:0] busy_mask, [6] track_full
    // decision words
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [wrrp_pkg::OUT_DATA_W-1:0]   m_axis_tdata   // [0] grant_valid, [3:1] grant_queue
);
    import wrrp_pkg::*;

    logic [BUSY_W-1:0]     in_busy_reg;
    logic                  in_full_reg;
    logic                  in_valid_reg;

    logic                  out_valid_reg;
    logic                  out_grant_reg;
    queue_t                out_queue_reg;

    queue_t                cur_queue_reg;
    queue_t                cur_queue_next;
    weight_t               turns_reg;
    weight_t               turns_next;
    weight_t               weight_reg [NUM_QUEUES];

    logic                  out_free;
    logic                  stage_fire;
    logic [NUM_QUEUES-1:0] eff_busy;
    queue_t                start_queue;
    weight_t               start_turns;
    logic                  found;
    logic                  first_hit;
    queue_t                pick_queue;
    logic                  grant_ok;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign stage_fire    = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;

    // busy bits per queue; queues without a busy bit never request
    genvar gi;
    generate
        for (gi = 0; gi < NUM_QUEUES; gi++)
        begin : g_busy
            if (gi < BUSY_W)
            begin : g_has_bit
                assign eff_busy[gi] = in_busy_reg[gi];
            end
            else
            begin : g_no_bit
                assign eff_busy[gi] = 1'b0;
            end
        end
    endgenerate

    // a spent turn count moves on before the search starts
    always_comb
    begin
        if (turns_reg == '0)
        begin
            start_queue = next_queue(cur_queue_reg);
        end
        else
        begin
            start_queue = cur_queue_reg;
        end
        if (turns_reg == '0)
        begin
            start_turns = weight_reg[start_queue];
        end
        else
        begin
            start_turns = turns_reg;
        end
    end

    // first busy queue in rotation from start_queue
    always_comb
    begin
        logic [QUEUE_W:0] sum;
        queue_t           cand;
        found      = 1'b0;
        first_hit  = 1'b0;
        pick_queue = '0;
        for (int k = 0; k < NUM_QUEUES; k++)
        begin
            sum = {1'b0, start_queue} + (QUEUE_W+1)'(k);
            if (sum >= (QUEUE_W+1)'(NUM_QUEUES))
            begin
                sum = sum - (QUEUE_W+1)'(NUM_QUEUES);
            end
            cand = sum[QUEUE_W-1:0];
            if (!found && eff_busy[cand])
            begin
                found      = 1'b1;
                first_hit  = (k == 0);
                pick_queue = cand;
            end
        end
    end

    assign grant_ok = found && !in_full_reg;

    always_comb
    begin
        cur_queue_next = cur_queue_reg;
        turns_next     = turns_reg;
        if (stage_fire && grant_ok)
        begin
            cur_queue_next = pick_queue;
            if (first_hit)
            begin
                turns_next = start_turns - weight_t'(1);
            end
            else
            begin
                turns_next = weight_reg[pick_queue] - weight_t'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cur_queue_reg <= '0;
            turns_reg     <= WEIGHT_RESET;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (out_free)
            begin
                out_valid_reg <= in_valid_reg;
            end
            cur_queue_reg <= cur_queue_next;
            turns_reg     <= turns_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_busy_reg <= s_axis_tdata[BUSY_W-1:0];
            in_full_reg <= s_axis_tdata[BUSY_W];
        end
        if (stage_fire)
        begin
            out_grant_reg <= grant_ok;
            out_queue_reg <= grant_ok ? pick_queue : queue_t'(0);
        end
    end

    // weights; queues without a register keep weight 1
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_QUEUES; i++)
            begin
                weight_reg[i] <= WEIGHT_RESET;
            end
        end
        else
        begin
            for (int i = 0; i < NUM_QUEUES; i++)
            begin
                if (cfg_wen && (i < WEIGHT_REGS) && (cfg_idx == CFG_IDX_W'(i)))
                begin
                    weight_reg[i] <= cfg_wdata;
                end
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W-QUEUE_W-1){1'b0}}, out_queue_reg, out_grant_reg};

    `WRRP_ASSERT(a_cur_queue_range,
        {1'b0, cur_queue_reg} < (QUEUE_W+1)'(NUM_QUEUES),
        "current queue out of range")
    `WRRP_ASSERT(a_grant_range,
        (m_axis_tvalid && out_grant_reg) |->
            ({1'b0, out_queue_reg} < (QUEUE_W+1)'(NUM_QUEUES)),
        "granted queue out of range")
    `WRRP_ASSERT(a_state_follows_grant,
        (stage_fire && grant_ok) |=> (cur_queue_reg == out_queue_reg && out_grant_reg),
        "state does not follow grant")
    `WRRP_ASSERT(a_no_grant_holds,
        (stage_fire && !grant_ok) |=>
            ($stable(cur_queue_reg) && $stable(turns_reg) && out_queue_reg == queue_t'(0)),
        "state moved without grant")

endmodule
